// ----- rtl/core/hrhp_pkg.sv -----
// Shared types, character constants and helpers for the request head parser.
`default_nettype none

package hrhp_pkg;

  // Byte values that the parser reacts to.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Last three head bytes that, followed by LF, end the head.
  localparam logic [23:0] HEAD_END_TAIL = 24'h0D0A0D;

  // Method names as they appear in the shift register of method characters.
  localparam logic [47:0] TXT_GET    = 48'h0000_0047_4554;
  localparam logic [47:0] TXT_POST   = 48'h0000_504F_5354;
  localparam logic [47:0] TXT_DELETE = 48'h4445_4C45_5445;
  localparam logic [47:0] TXT_PUT    = 48'h0000_0050_5554;
  localparam logic [2:0]  LEN_GET    = 3'd3;
  localparam logic [2:0]  LEN_POST   = 3'd4;
  localparam logic [2:0]  LEN_DELETE = 3'd6;
  localparam logic [2:0]  LEN_PUT    = 3'd3;
  localparam logic [2:0]  METHOD_CHARS_MAX = 3'd7;

  // Length of the header key "content-length".
  localparam logic [3:0] KEY_LEN      = 4'd14;
  localparam logic [3:0] KEY_POS_MAX  = 4'd15;

  typedef enum logic [2:0] {
    ROLE_METHOD  = 3'd0,
    ROLE_PATH    = 3'd1,
    ROLE_HEAD    = 3'd2,
    ROLE_BODY    = 3'd3,
    ROLE_IGNORED = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_METHOD = 2'd2,
    ST_NO_PATH    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    M_GET    = 2'd0,
    M_POST   = 2'd1,
    M_DELETE = 2'd2,
    M_PUT    = 2'd3
  } method_t;

  // One incoming byte of the request stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  // One tagged byte.
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [2:0]  byte_role;
    logic        head_complete;
    logic [31:0] content_length;
    logic        request_done;
    logic [1:0]  status;
    logic [1:0]  method_code;
  } out_t;

  // Content-Length status handed from the length scanner to the top level.
  typedef struct packed {
    logic found;
    logic error;
  } len_info_t;

  // Final verdict on method and path.
  typedef struct packed {
    status_t status;
    method_t method;
  } verdict_t;

  // Lower-case header key, one character per position.
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Status and method code at the end of a request.
  function automatic verdict_t final_verdict(input logic [47:0] chars,
                                             input logic [2:0] count,
                                             input logic closed);
    verdict_t v;
    logic     known;
    method_t  m;
    known = 1'b1;
    m     = M_GET;
    priority if (count == LEN_GET && chars == TXT_GET) begin
      m = M_GET;
    end else if (count == LEN_POST && chars == TXT_POST) begin
      m = M_POST;
    end else if (count == LEN_DELETE && chars == TXT_DELETE) begin
      m = M_DELETE;
    end else if (count == LEN_PUT && chars == TXT_PUT) begin
      m = M_PUT;
    end else begin
      known = 1'b0;
    end
    if (!known) begin
      v.status = ST_BAD_METHOD;
      v.method = M_GET;
    end else if (!closed) begin
      v.status = ST_NO_PATH;
      v.method = M_GET;
    end else begin
      v.status = ST_OK;
      v.method = m;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hrhp_length_scan.sv -----
// Content-Length header search and value decoding, one head byte per cycle while accept is high.
`default_nettype none

module hrhp_length_scan #(
  parameter int LENGTH_WIDTH     = 32,
  parameter int VALUE_CHAR_LIMIT = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      clear,
  input  logic                      active,
  input  logic [7:0]                data_byte,
  output hrhp_pkg::len_info_t       len_info,
  output logic [LENGTH_WIDTH-1:0]   len_value
);
  import hrhp_pkg::*;

  localparam int CW = $clog2(VALUE_CHAR_LIMIT + 1);
  localparam logic [CW-1:0] CHAR_LIMIT = CW'(VALUE_CHAR_LIMIT);
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

  // Value stages: key, skip line, skip blanks, whitespace, sign, digits, settled.
  typedef enum logic [2:0] {
    VS_KEY    = 3'd0,
    VS_SKIP   = 3'd1,
    VS_BLANKS = 3'd2,
    VS_SPACE  = 3'd3,
    VS_SIGN   = 3'd4,
    VS_DIGITS = 3'd5,
    VS_SETTLE = 3'd6
  } vstage_t;

  vstage_t                 stage, stage_next, cur_stage;
  logic [3:0]              key_pos, key_pos_next, cur_key_pos;
  logic                    key_match, key_match_next, cur_key_match;
  logic [CW-1:0]           char_cnt, char_cnt_next, cur_char_cnt;
  logic [LENGTH_WIDTH-1:0] acc, acc_next, cur_acc;
  logic                    fl_found, fl_found_next, cur_found;
  logic                    fl_error, fl_error_next, cur_error;
  logic                    fl_neg, fl_neg_next, cur_neg;

  logic [7:0]              lc;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [LENGTH_WIDTH+3:0] product;

  // A first byte starts from the cleared state.
  always_comb begin
    cur_stage     = clear ? VS_KEY : stage;
    cur_key_pos   = clear ? '0 : key_pos;
    cur_key_match = clear ? 1'b1 : key_match;
    cur_char_cnt  = clear ? '0 : char_cnt;
    cur_acc       = clear ? '0 : acc;
    cur_found     = clear ? 1'b0 : fl_found;
    cur_error     = clear ? 1'b0 : fl_error;
    cur_neg       = clear ? 1'b0 : fl_neg;
  end

  // Byte classification and one decimal step.
  always_comb begin
    lc = (data_byte >= CH_UP_A && data_byte <= CH_UP_Z) ? data_byte + CASE_OFS : data_byte;
    is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    digit    = 4'(data_byte - CH_ZERO);
    product  = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1)
             + (LENGTH_WIDTH + 4)'(digit);
  end

  // Header line state machine for the key and its value.
  always_comb begin
    logic cont;
    cont           = 1'b1;
    stage_next     = cur_stage;
    key_pos_next   = cur_key_pos;
    key_match_next = cur_key_match;
    char_cnt_next  = cur_char_cnt;
    acc_next       = cur_acc;
    fl_found_next  = cur_found;
    fl_error_next  = cur_error;
    fl_neg_next    = cur_neg;

    if (active) begin
      if (cur_stage == VS_KEY) begin
        if (data_byte == CH_LF) begin
          key_pos_next   = '0;
          key_match_next = 1'b1;
        end else if (data_byte == CH_COLON) begin
          if (cur_key_match && cur_key_pos == KEY_LEN) begin
            stage_next    = VS_BLANKS;
            fl_found_next = 1'b1;
            acc_next      = '0;
            char_cnt_next = '0;
          end else begin
            stage_next = VS_SKIP;
          end
        end else begin
          if (cur_key_pos >= KEY_LEN || lc != key_char(cur_key_pos)) begin
            key_match_next = 1'b0;
          end
          if (cur_key_pos < KEY_POS_MAX) begin
            key_pos_next = cur_key_pos + 4'd1;
          end
        end
      end else if (cur_stage == VS_SKIP) begin
        if (data_byte == CH_LF) begin
          stage_next     = VS_KEY;
          key_pos_next   = '0;
          key_match_next = 1'b1;
        end
      end else if (cur_stage != VS_SETTLE) begin
        // Value parsing; LF, a stray byte or reaching the character limit settles the value.
        if (data_byte == CH_LF) begin
          cont = 1'b0;
          if (cur_stage != VS_DIGITS || (cur_neg && cur_acc != '0)) begin
            fl_error_next = 1'b1;
          end
          stage_next = VS_SETTLE;
        end else if (cur_stage == VS_BLANKS) begin
          if (data_byte == CH_SP || data_byte == CH_TAB) begin
            cont = 1'b0;
          end else begin
            stage_next = VS_SPACE;
          end
        end
        if (cont) begin
          if (cur_char_cnt >= CHAR_LIMIT) begin
            cont = 1'b0;
            if (stage_next != VS_DIGITS || (cur_neg && cur_acc != '0)) begin
              fl_error_next = 1'b1;
            end
            stage_next = VS_SETTLE;
          end else begin
            char_cnt_next = cur_char_cnt + CW'(1);
          end
        end
        if (cont && stage_next == VS_SPACE) begin
          if (data_byte == CH_SP || data_byte == CH_TAB || data_byte == CH_CR ||
              data_byte == CH_VT || data_byte == CH_FF) begin
            cont = 1'b0;
          end else if (data_byte == CH_PLUS) begin
            cont       = 1'b0;
            stage_next = VS_SIGN;
          end else if (data_byte == CH_MINUS) begin
            cont        = 1'b0;
            fl_neg_next = 1'b1;
            stage_next  = VS_SIGN;
          end else begin
            stage_next = VS_SIGN;
          end
        end
        if (cont) begin
          if (is_digit) begin
            if (stage_next == VS_SIGN) begin
              acc_next   = LENGTH_WIDTH'(digit);
              stage_next = VS_DIGITS;
            end else if (product[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) begin
              acc_next = LEN_MAX;
            end else begin
              acc_next = product[LENGTH_WIDTH-1:0];
            end
          end else begin
            if (stage_next != VS_DIGITS || (cur_neg && cur_acc != '0)) begin
              fl_error_next = 1'b1;
            end
            stage_next = VS_SETTLE;
          end
        end
      end
    end
  end

  // Results reflect this byte.
  always_comb begin
    len_info.found = fl_found_next;
    len_info.error = fl_error_next;
    len_value      = (fl_found_next && !fl_error_next) ? acc_next : '0;
  end

  // Scanner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= VS_KEY;
      key_pos   <= '0;
      key_match <= 1'b1;
      char_cnt  <= '0;
      acc       <= '0;
      fl_found  <= 1'b0;
      fl_error  <= 1'b0;
      fl_neg    <= 1'b0;
    end else if (accept) begin
      stage     <= stage_next;
      key_pos   <= key_pos_next;
      key_match <= key_match_next;
      char_cnt  <= char_cnt_next;
      acc       <= acc_next;
      fl_found  <= fl_found_next;
      fl_error  <= fl_error_next;
      fl_neg    <= fl_neg_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/http_request_head_parser.sv -----
// Top level of the request head parser: byte tagging, head end, body count.
// The tagged result of each accepted byte is held in the result register.
// Throughput: one byte per cycle; the result register decouples the two sides,
// so a new byte is taken whenever the result is empty or is being taken.
// The input stalls only while a result waits and the output is stalled.
// Reset clears parser state and the result valid; first_byte clears the state too.
`default_nettype none

module http_request_head_parser #(
  parameter int LENGTH_WIDTH     = 32,
  parameter int VALUE_CHAR_LIMIT = 31
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  hrhp_pkg::in_t  byte_data,
  output logic           tag_valid,
  input  logic           tag_stall,
  output hrhp_pkg::out_t tag_data
);
  import hrhp_pkg::*;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_HEAD,
    PH_BODY,
    PH_DONE
  } phase_t;

  phase_t                  phase, phase_next, cur_phase;
  logic [47:0]             method_chars, method_chars_next, cur_chars;
  logic [2:0]              method_count, method_count_next, cur_count;
  logic                    path_closed, path_closed_next, cur_closed;
  logic [23:0]             recent_bytes, recent_bytes_next, cur_recent;
  logic [LENGTH_WIDTH-1:0] body_remaining, body_remaining_next, cur_remaining;

  logic                    accept;
  logic                    active;
  logic [7:0]              b;
  len_info_t               len_info;
  logic [LENGTH_WIDTH-1:0] len_value;
  logic [31:0]             len_low;
  out_t                    res;
  verdict_t                verdict;

  // Handshake: the result register holds until taken.
  assign byte_stall = tag_valid & tag_stall;
  assign accept     = byte_valid & ~byte_stall;
  assign b          = byte_data.data_byte;

  // A first byte starts from the cleared state.
  always_comb begin
    cur_phase     = byte_data.first_byte ? PH_METHOD : phase;
    cur_chars     = byte_data.first_byte ? '0 : method_chars;
    cur_count     = byte_data.first_byte ? '0 : method_count;
    cur_closed    = byte_data.first_byte ? 1'b0 : path_closed;
    cur_recent    = byte_data.first_byte ? '0 : recent_bytes;
    cur_remaining = byte_data.first_byte ? '0 : body_remaining;
  end

  assign active = (cur_phase == PH_METHOD) || (cur_phase == PH_PATH) ||
                  (cur_phase == PH_HEAD);

  hrhp_length_scan #(
    .LENGTH_WIDTH     (LENGTH_WIDTH),
    .VALUE_CHAR_LIMIT (VALUE_CHAR_LIMIT)
  ) u_length_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .clear     (byte_data.first_byte),
    .active    (active),
    .data_byte (b),
    .len_info  (len_info),
    .len_value (len_value)
  );

  // Low 32 bits of the length for the output field, zero-extended if the length is narrower.
  generate
    if (LENGTH_WIDTH >= 32) begin : g_len_cut
      assign len_low = len_value[31:0];
    end else begin : g_len_ext
      assign len_low = {{(32 - LENGTH_WIDTH){1'b0}}, len_value};
    end
  endgenerate

  // Per-byte phase logic and result.
  always_comb begin
    phase_next          = cur_phase;
    method_chars_next   = cur_chars;
    method_count_next   = cur_count;
    path_closed_next    = cur_closed;
    recent_bytes_next   = cur_recent;
    body_remaining_next = cur_remaining;
    verdict             = final_verdict(cur_chars, cur_count, cur_closed);
    res.echo_byte       = b;
    res.byte_role       = ROLE_IGNORED;
    res.head_complete   = 1'b0;
    res.request_done    = 1'b0;
    res.status          = ST_OK;
    res.method_code     = M_GET;
    res.content_length  = '0;

    unique case (cur_phase)
      PH_METHOD, PH_PATH, PH_HEAD: begin
        if (cur_phase == PH_METHOD) begin
          if (b == CH_SP) begin
            res.byte_role = ROLE_HEAD;
            phase_next    = PH_PATH;
          end else begin
            res.byte_role = ROLE_METHOD;
            if (cur_count < METHOD_CHARS_MAX) begin
              method_chars_next = {cur_chars[39:0], b};
              method_count_next = cur_count + 3'd1;
            end
          end
        end else if (cur_phase == PH_PATH) begin
          if (b == CH_SP) begin
            res.byte_role    = ROLE_HEAD;
            path_closed_next = 1'b1;
            phase_next       = PH_HEAD;
          end else begin
            res.byte_role = ROLE_PATH;
          end
        end else begin
          res.byte_role = ROLE_HEAD;
        end
        // The verdict sees the method and path as updated by this byte.
        verdict = final_verdict(method_chars_next, method_count_next, path_closed_next);
        // End of head: abort, finish at once, or start counting the body.
        if (b == CH_LF && cur_recent == HEAD_END_TAIL) begin
          res.head_complete = 1'b1;
          if (len_info.found && len_info.error) begin
            res.request_done = 1'b1;
            res.status       = ST_BAD_LENGTH;
            phase_next       = PH_DONE;
          end else if (len_value == '0) begin
            res.request_done = 1'b1;
            res.status       = verdict.status;
            res.method_code  = verdict.method;
            phase_next       = PH_DONE;
          end else begin
            body_remaining_next = len_value;
            phase_next          = PH_BODY;
          end
        end
        recent_bytes_next = {cur_recent[15:0], b};
      end
      PH_BODY: begin
        res.byte_role = ROLE_BODY;
        if (cur_remaining != '0) begin
          body_remaining_next = cur_remaining - LENGTH_WIDTH'(1);
        end
        if (body_remaining_next == '0) begin
          res.request_done = 1'b1;
          res.status       = verdict.status;
          res.method_code  = verdict.method;
          phase_next       = PH_DONE;
        end
      end
      PH_DONE: begin
        res.byte_role = ROLE_IGNORED;
      end
      default: begin
        res.byte_role = ROLE_IGNORED;
      end
    endcase

    if (phase_next == PH_BODY || phase_next == PH_DONE) begin
      res.content_length = len_low;
    end
  end

  // Parser state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_METHOD;
      method_chars   <= '0;
      method_count   <= '0;
      path_closed    <= 1'b0;
      recent_bytes   <= '0;
      body_remaining <= '0;
      tag_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        method_chars   <= method_chars_next;
        method_count   <= method_count_next;
        path_closed    <= path_closed_next;
        recent_bytes   <= recent_bytes_next;
        body_remaining <= body_remaining_next;
        tag_data       <= res;
      end
      tag_valid <= accept | (tag_valid & tag_stall);
    end
  end

  // The head only ends on a line feed.
  assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_data.head_complete |-> tag_data.echo_byte == CH_LF)
    else $error("head_complete on a byte other than LF");

  // A failed request carries no method code.
  assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_data.request_done && tag_data.status != ST_OK
    |-> tag_data.method_code == M_GET)
    else $error("method code set on a failed request");

  // Ignored bytes neither end the head nor the request.
  assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_data.byte_role == ROLE_IGNORED
    |-> !tag_data.request_done && !tag_data.head_complete)
    else $error("ignored byte flagged as done or head end");

  // Once done, only a first byte leaves the done phase.
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DONE && !byte_data.first_byte |=> phase == PH_DONE)
    else $error("left done phase without a first byte");

  // A body byte is only tagged while a body count is pending.
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_BODY && !byte_data.first_byte |-> body_remaining != '0)
    else $error("body phase with no remaining count");

endmodule

`default_nettype wire
